>>> hw/rtl/stsr_pkg.sv
// Shared types, constants and helper functions for the timed stepper run block.
package stsr_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_STALL_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_TIME      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEANING_LENGTH = 2'd2;

    localparam logic [11:0] RST_STALL_THRESHOLD = 12'd1350;
    localparam logic [7:0]  RST_STALL_TIME      = 8'd100;
    localparam logic [15:0] RST_CLEANING_LENGTH = 16'd15000;

    localparam logic [4:0] RST_PRESCALE = 5'd3;
    localparam logic [7:0] EXAM_MAX     = 8'd255;

    localparam logic       CMD_START = 1'b0;
    localparam logic       CMD_TICK  = 1'b1;
    localparam logic [2:0] SPEED_STALL_CHECK = 3'd4;

    localparam logic [2:0] SPEED_FAST   = 3'd1;
    localparam logic [2:0] SPEED_MEDIUM = 3'd2;
    localparam logic [2:0] SPEED_QUICK  = 3'd3;
    localparam logic [4:0] RELOAD_FAST    = 5'd3;
    localparam logic [4:0] RELOAD_MEDIUM  = 5'd6;
    localparam logic [4:0] RELOAD_QUICK   = 5'd2;
    localparam logic [4:0] RELOAD_DEFAULT = 5'd20;

    localparam logic [3:0] PHASE_A_TOP = 4'd7;
    localparam logic [3:0] PHASE_B_TOP = 4'd9;
    localparam logic [3:0] PHASE_C_TOP = 4'd11;
    localparam logic [3:0] PHASE_D_TOP = 4'd13;
    localparam logic [3:0] PHASE_A_FLOOR = 4'd0;
    localparam logic [3:0] PHASE_B_FLOOR = 4'd2;
    localparam logic [3:0] PHASE_C_FLOOR = 4'd4;
    localparam logic [3:0] PHASE_D_FLOOR = 4'd6;
    localparam logic [3:0] WINDOW_LEN    = 4'd5;

    typedef struct packed {
        logic        cmd;
        logic        direction;
        logic [2:0]  speed_code;
        logic [15:0] run_ticks;
        logic [11:0] adc_sample;
    } t_in_item;

    typedef struct packed {
        logic coil_one;
        logic coil_two;
        logic coil_three;
        logic coil_four;
        logic running;
        logic finished;
        logic stalled;
        logic buzzer_request;
    } t_out_item;

    typedef struct packed {
        logic [11:0] stall_threshold;
        logic [7:0]  stall_time;
        logic [15:0] cleaning_length;
    } t_cfg;

    typedef struct packed {
        logic [4:0]  prescale_count;
        logic [3:0]  phase_a;
        logic [3:0]  phase_b;
        logic [3:0]  phase_c;
        logic [3:0]  phase_d;
        logic [15:0] ticks_left;
        logic        run_active;
        logic        cleaning_run;
        logic        dir_latched;
        logic [2:0]  speed_latched;
        logic [7:0]  exam_count;
        logic        buzz_flag;
    } t_state;

    function automatic logic [4:0] reload_for(input logic [2:0] code);
        logic [4:0] r;
        case (code)
            SPEED_FAST:   r = RELOAD_FAST;
            SPEED_MEDIUM: r = RELOAD_MEDIUM;
            SPEED_QUICK:  r = RELOAD_QUICK;
            default:      r = RELOAD_DEFAULT;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] phase_next(input logic [3:0] p, input logic [3:0] top,
                                              input logic [3:0] floor);
        logic [4:0] s;
        s = {1'b0, p} + 5'd1;
        return (s > {1'b0, top}) ? floor : s[3:0];
    endfunction

    function automatic logic in_window(input logic [3:0] p, input logic [3:0] floor);
        logic [4:0] hi;
        hi = {1'b0, floor} + {1'b0, WINDOW_LEN};
        return (p >= floor) && ({1'b0, p} < hi);
    endfunction

endpackage

>>> hw/rtl/stsr_cfg_regs.sv
// Configuration register file for the stall threshold, stall time and cleaning length.
module stsr_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [stsr_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  logic [stsr_pkg::CFG_DATA_W-1:0]  i_wr_data,
    output stsr_pkg::t_cfg                   o_cfg
);

    stsr_pkg::t_cfg r_cfg;
    stsr_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                stsr_pkg::CFG_STALL_THRESHOLD: n_cfg.stall_threshold = i_wr_data[11:0];
                stsr_pkg::CFG_STALL_TIME:      n_cfg.stall_time      = i_wr_data[7:0];
                stsr_pkg::CFG_CLEANING_LENGTH: n_cfg.cleaning_length = i_wr_data[15:0];
                default:                       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stall_threshold <= stsr_pkg::RST_STALL_THRESHOLD;
            r_cfg.stall_time      <= stsr_pkg::RST_STALL_TIME;
            r_cfg.cleaning_length <= stsr_pkg::RST_CLEANING_LENGTH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/stsr_step.sv
// Run state registers and the single-pass update that turns one beat into one result.
module stsr_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  stsr_pkg::t_in_item  i_item,
    input  stsr_pkg::t_cfg      i_cfg,
    output stsr_pkg::t_out_item o_result
);

    stsr_pkg::t_state r_st;
    stsr_pkg::t_state n_st;

    always_comb begin
        logic [4:0] pre_dec;
        logic       wa, wb, wc, wd;
        logic       fin, stl;
        n_st     = r_st;
        fin      = 1'b0;
        stl      = 1'b0;
        o_result = '0;
        pre_dec  = r_st.prescale_count - 5'd1;

        if (i_item.cmd == stsr_pkg::CMD_START) begin
            n_st.dir_latched   = i_item.direction;
            n_st.speed_latched = i_item.speed_code;
            n_st.ticks_left    = i_item.run_ticks;
            n_st.cleaning_run  = i_item.run_ticks > i_cfg.cleaning_length;
            n_st.run_active    = i_item.run_ticks != 16'd0;
            fin                = i_item.run_ticks == 16'd0;
        end else begin
            if (r_st.exam_count < stsr_pkg::EXAM_MAX) begin
                n_st.exam_count = r_st.exam_count + 8'd1;
            end
            if (r_st.run_active) begin
                n_st.ticks_left     = r_st.ticks_left - 16'd1;
                n_st.prescale_count = pre_dec;
                if (pre_dec == 5'd0) begin
                    n_st.phase_a = stsr_pkg::phase_next(r_st.phase_a, stsr_pkg::PHASE_A_TOP,
                                                        stsr_pkg::PHASE_A_FLOOR);
                    n_st.phase_b = stsr_pkg::phase_next(r_st.phase_b, stsr_pkg::PHASE_B_TOP,
                                                        stsr_pkg::PHASE_B_FLOOR);
                    n_st.phase_c = stsr_pkg::phase_next(r_st.phase_c, stsr_pkg::PHASE_C_TOP,
                                                        stsr_pkg::PHASE_C_FLOOR);
                    n_st.phase_d = stsr_pkg::phase_next(r_st.phase_d, stsr_pkg::PHASE_D_TOP,
                                                        stsr_pkg::PHASE_D_FLOOR);
                    n_st.prescale_count = stsr_pkg::reload_for(r_st.speed_latched);
                end
                if (r_st.speed_latched == stsr_pkg::SPEED_STALL_CHECK) begin
                    if ((i_item.adc_sample > i_cfg.stall_threshold) && !r_st.cleaning_run) begin
                        if (n_st.exam_count > i_cfg.stall_time) begin
                            n_st.run_active = 1'b0;
                            n_st.buzz_flag  = 1'b1;
                            fin             = 1'b1;
                            stl             = 1'b1;
                        end
                    end else begin
                        n_st.exam_count = 8'd0;
                    end
                end
                if (n_st.run_active && (n_st.ticks_left == 16'd0)) begin
                    n_st.run_active = 1'b0;
                    fin             = 1'b1;
                end
            end
        end

        wa = n_st.phase_a < stsr_pkg::WINDOW_LEN;
        wb = stsr_pkg::in_window(n_st.phase_b, stsr_pkg::PHASE_B_FLOOR);
        wc = stsr_pkg::in_window(n_st.phase_c, stsr_pkg::PHASE_C_FLOOR);
        wd = stsr_pkg::in_window(n_st.phase_d, stsr_pkg::PHASE_D_FLOOR);

        if (n_st.run_active) begin
            if (n_st.dir_latched) begin
                o_result.coil_one   = wa;
                o_result.coil_two   = wb;
                o_result.coil_four  = wc;
                o_result.coil_three = wd;
            end else begin
                o_result.coil_three = wa;
                o_result.coil_four  = wb;
                o_result.coil_two   = wc;
                o_result.coil_one   = wd;
            end
        end
        o_result.running        = n_st.run_active;
        o_result.finished       = fin;
        o_result.stalled        = stl;
        o_result.buzzer_request = n_st.buzz_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.prescale_count <= stsr_pkg::RST_PRESCALE;
            r_st.phase_a        <= 4'd0;
            r_st.phase_b        <= 4'd0;
            r_st.phase_c        <= 4'd0;
            r_st.phase_d        <= 4'd0;
            r_st.ticks_left     <= 16'd0;
            r_st.run_active     <= 1'b0;
            r_st.cleaning_run   <= 1'b0;
            r_st.dir_latched    <= 1'b0;
            r_st.speed_latched  <= 3'd0;
            r_st.exam_count     <= 8'd0;
            r_st.buzz_flag      <= 1'b0;
        end else if (i_fire) begin
            r_st <= n_st;
        end
    end

endmodule

>>> hw/rtl/stepper_timed_run_stall_stop_top.sv
// Top level of the timed stepper run with stall stop: beat registers and block wiring.
//
//   channel | direction | handshake              | payload
//   in      | sink      | i_in_valid / o_in_stall   | t_in_item
//   out     | source    | o_out_valid / i_out_stall | t_out_item
//   cfg     | sink      | i_cfg_valid / o_cfg_ready | index + data
//
// One beat per cycle unless the out side stalls; a beat passes the input
// register, then the result register. Run state updates as the beat leaves
// the input register. Reset is synchronous and sets all run state and the
// registers to their defaults. A stall on the out side holds the result
// register and, once the input register is full too, raises o_in_stall.
module stepper_timed_run_stall_stop_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  stsr_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output stsr_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [stsr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [stsr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic                r_in_valid;
    stsr_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    stsr_pkg::t_out_item r_out_item;
    stsr_pkg::t_out_item step_result;
    stsr_pkg::t_cfg      cfg;
    logic                out_free;
    logic                fire;
    logic                in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !out_free;
    assign o_cfg_ready = 1'b1;

    stsr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    stsr_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_data;
        end
        if (fire) begin
            r_out_item <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

>>> hw/rtl/stsr_checker.sv
// Port-level checks for the timed stepper run block, bound to its top level.
module stsr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input stsr_pkg::t_out_item o_out_data
);

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

    a_coils_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.running |->
            !o_out_data.coil_one && !o_out_data.coil_two &&
            !o_out_data.coil_three && !o_out_data.coil_four)
        else $error("coil driven with no run active");

    a_stall_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.stalled |->
            o_out_data.finished && o_out_data.buzzer_request && !o_out_data.running)
        else $error("stall result without end of run and buzzer");

    a_finish_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.finished |-> !o_out_data.running)
        else $error("finished result still running");

    a_no_stall_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while result register empty");

endmodule

bind stepper_timed_run_stall_stop_top stsr_checker u_stsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
